### hw/rtl/wedm_pkg.sv
// ----------------------------------------------------------------------------
// wedm_pkg: shared types and constants of the weighted edit distance unit
// Transaction types, command codes, controller states, the command and status
// bundles between controller and datapath, and saturating arithmetic helpers.
// ----------------------------------------------------------------------------
package wedm_pkg;

	localparam int DIST_W  = 24;
	localparam int COST_W  = 16;
	localparam int SYM_W   = 8;
	localparam int ENTRY_W = SYM_W + DIST_W;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_REPLACE = 2'd0;
	localparam logic [1:0] REG_INSERT  = 2'd1;
	localparam logic [1:0] REG_DELETE  = 2'd2;
	localparam logic [1:0] REG_MERGE   = 2'd3;

	localparam logic [COST_W-1:0] COST_RESET = COST_W'(1);

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_TARGET = 2'd2,
		CMD_ANSWER = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [SYM_W-1:0] symbol;
	} in_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              source_overflow;
	} out_t;

	typedef struct packed {
		logic [COST_W-1:0] replace_cost;
		logic [COST_W-1:0] insert_cost;
		logic [COST_W-1:0] delete_cost;
		logic [COST_W-1:0] merge_cost;
	} costs_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic append;
		logic start_pass;
		logic issue;
		logic emit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic len_zero;
		logic last_issue;
		logic pipe_empty;
		logic out_busy;
	} dp_status_t;

	function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
		input logic [COST_W-1:0] b);
		logic [DIST_W:0] s;
		s = {1'b0, a} + {{(DIST_W + 1 - COST_W){1'b0}}, b};
		return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
	endfunction

	function automatic logic [DIST_W-1:0] min2(input logic [DIST_W-1:0] a,
		input logic [DIST_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

endpackage

### hw/rtl/wedm_ram.sv
// ----------------------------------------------------------------------------
// wedm_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module wedm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/wedm_ctrl.sv
// ----------------------------------------------------------------------------
// wedm_ctrl: command decode and sequencing
// Accepts input transactions, decodes commands and steps the column pass.
// ----------------------------------------------------------------------------
module wedm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  wedm_pkg::cmd_t      in_cmd,
	output logic                in_stall,
	input  logic                out_stall,
	input  wedm_pkg::dp_status_t status,
	output wedm_pkg::ctrl_cmd_t command
);

	wedm_pkg::state_t state_q, state_d;
	logic             accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wedm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		command  = '0;
		// An answer waits while the previous result is still held at the output.
		in_stall = (state_q != wedm_pkg::ST_IDLE) ||
			((in_cmd == wedm_pkg::CMD_ANSWER) && status.out_busy && out_stall);
		accept   = in_valid && !in_stall;

		case (state_q)
			wedm_pkg::ST_IDLE: begin
				if (accept) begin
					case (in_cmd)
						wedm_pkg::CMD_CLEAR:  command.clear = 1'b1;
						wedm_pkg::CMD_APPEND: command.append = 1'b1;
						wedm_pkg::CMD_TARGET: begin
							command.start_pass = 1'b1;
							if (!status.len_zero) begin
								state_d = wedm_pkg::ST_RUN;
							end
						end
						wedm_pkg::CMD_ANSWER: command.emit = 1'b1;
						default: ;
					endcase
				end
			end
			wedm_pkg::ST_RUN: begin
				command.issue = 1'b1;
				if (status.last_issue) begin
					state_d = wedm_pkg::ST_DRAIN;
				end
			end
			wedm_pkg::ST_DRAIN: begin
				if (status.pipe_empty) begin
					state_d = wedm_pkg::ST_IDLE;
				end
			end
			default: state_d = wedm_pkg::ST_IDLE;
		endcase
	end

endmodule

### hw/rtl/wedm_dp.sv
// ----------------------------------------------------------------------------
// wedm_dp: cost column datapath
// Holds the source symbols and cost column in one RAM and updates the column
// one entry per cycle through a two-stage recurrence pipeline.
// ----------------------------------------------------------------------------
module wedm_dp #(
	parameter int MAX_SOURCE_LEN = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wedm_pkg::ctrl_cmd_t  command,
	input  logic [wedm_pkg::SYM_W-1:0] symbol,
	input  wedm_pkg::costs_t     costs,
	output wedm_pkg::dp_status_t status,
	output logic                 out_valid,
	input  logic                 out_stall,
	output wedm_pkg::out_t       out_data
);

	localparam int AW = (MAX_SOURCE_LEN > 1) ? $clog2(MAX_SOURCE_LEN) : 1;
	localparam int LW = $clog2(MAX_SOURCE_LEN + 1);

	// Problem state. Entry 0 of the column lives in a register; entry i >= 1 is
	// stored at RAM address i-1 next to source symbol i-1. tail_q mirrors the
	// column entry at the current source length.
	logic [LW-1:0]              len_q;
	logic                       ovf_q;
	logic [wedm_pkg::DIST_W-1:0] col0_q;
	logic [wedm_pkg::DIST_W-1:0] tail_q;
	logic [wedm_pkg::SYM_W-1:0]  tsym_q;

	// Pass pipeline.
	logic [AW-1:0]              rd_idx_q;
	logic [AW-1:0]              wr_idx_q;
	logic                       rv_s1;
	logic                       first_s1;
	logic [wedm_pkg::DIST_W-1:0] prev1_q;
	logic [wedm_pkg::DIST_W-1:0] prev2_q;
	logic [wedm_pkg::DIST_W-1:0] newprev_q;
	logic                       v_s2;
	logic [wedm_pkg::DIST_W-1:0] part_s2;
	logic [wedm_pkg::SYM_W-1:0]  asym_s2;

	logic                       out_v_q;
	wedm_pkg::out_t             out_q;

	// RAM interface.
	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [wedm_pkg::ENTRY_W-1:0] ram_wdata;
	logic [wedm_pkg::ENTRY_W-1:0] ram_rdata;

	logic [wedm_pkg::SYM_W-1:0]  rd_sym;
	logic [wedm_pkg::DIST_W-1:0] rd_cost;
	logic [wedm_pkg::DIST_W-1:0] diag_c;
	logic [wedm_pkg::DIST_W-1:0] ins_c;
	logic [wedm_pkg::DIST_W-1:0] mrg_c;
	logic [wedm_pkg::DIST_W-1:0] part_c;
	logic [wedm_pkg::DIST_W-1:0] new_c;
	logic [wedm_pkg::DIST_W-1:0] col0_new;
	logic [wedm_pkg::DIST_W-1:0] load_c;
	logic                        full;

	wedm_ram #(
		.WIDTH(wedm_pkg::ENTRY_W),
		.DEPTH(MAX_SOURCE_LEN)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_idx_q),
		.rdata(ram_rdata)
	);

	assign full     = (len_q == LW'(MAX_SOURCE_LEN));
	assign col0_new = wedm_pkg::sat_add(col0_q, costs.insert_cost);
	assign load_c   = wedm_pkg::sat_add(tail_q, costs.delete_cost);

	// Stage 1: the three terms that depend only on the old column.
	assign rd_sym  = ram_rdata[wedm_pkg::ENTRY_W-1 -: wedm_pkg::SYM_W];
	assign rd_cost = ram_rdata[wedm_pkg::DIST_W-1:0];
	assign diag_c  = (rd_sym == tsym_q) ? prev1_q
		: wedm_pkg::sat_add(prev1_q, costs.replace_cost);
	assign ins_c   = wedm_pkg::sat_add(rd_cost, costs.insert_cost);
	assign mrg_c   = first_s1 ? wedm_pkg::DIST_MAX
		: wedm_pkg::sat_add(prev2_q, costs.merge_cost);
	assign part_c  = wedm_pkg::min2(wedm_pkg::min2(ins_c, diag_c), mrg_c);

	// Stage 2: fold in the delete term from the freshly computed entry below.
	assign new_c = wedm_pkg::min2(part_s2, wedm_pkg::sat_add(newprev_q, costs.delete_cost));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_idx_q;
		ram_wdata = {asym_s2, new_c};
		if (v_s2) begin
			ram_we = 1'b1;
		end else if (command.append && !full) begin
			ram_we    = 1'b1;
			ram_waddr = len_q[AW-1:0];
			ram_wdata = {symbol, load_c};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			ovf_q    <= 1'b0;
			col0_q   <= '0;
			tail_q   <= '0;
			rd_idx_q <= '0;
			wr_idx_q <= '0;
			rv_s1    <= 1'b0;
			first_s1 <= 1'b0;
			v_s2     <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			rv_s1    <= command.issue;
			first_s1 <= command.issue && (rd_idx_q == '0);
			v_s2     <= rv_s1;

			if (command.clear) begin
				len_q  <= '0;
				ovf_q  <= 1'b0;
				col0_q <= '0;
				tail_q <= '0;
			end
			if (command.append) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					len_q  <= len_q + LW'(1);
					tail_q <= load_c;
				end
			end
			if (command.start_pass) begin
				col0_q   <= col0_new;
				tail_q   <= col0_new;
				rd_idx_q <= '0;
				wr_idx_q <= '0;
			end
			if (command.issue) begin
				rd_idx_q <= rd_idx_q + AW'(1);
			end
			if (v_s2) begin
				wr_idx_q <= wr_idx_q + AW'(1);
				tail_q   <= new_c;
			end

			if (command.emit) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && !out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (command.start_pass) begin
			tsym_q    <= symbol;
			prev1_q   <= col0_q;
			newprev_q <= col0_new;
		end
		if (rv_s1) begin
			prev1_q <= rd_cost;
			prev2_q <= prev1_q;
			part_s2 <= part_c;
			asym_s2 <= rd_sym;
		end
		if (v_s2) begin
			newprev_q <= new_c;
		end
		if (command.emit) begin
			out_q.distance        <= tail_q;
			out_q.source_overflow <= ovf_q;
		end
	end

	assign status.len_zero   = (len_q == '0);
	assign status.last_issue = ((LW'(rd_idx_q) + LW'(1)) == len_q);
	assign status.pipe_empty = !rv_s1 && !v_s2;
	assign status.out_busy   = out_v_q;

	assign out_valid = out_v_q;
	assign out_data  = out_q;

endmodule

### hw/rtl/weighted_edit_distance_merge_unit.sv
// ----------------------------------------------------------------------------
// weighted_edit_distance_merge_unit: weighted edit distance with merge edit
// Computes the minimum weighted cost of turning a loaded source string into
// the target symbols streamed so far, using substitute, insert, delete and a
// merge of two source symbols into one target symbol.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload                        Handshake
//  -------  ---------  -----------------------------  ----------------------
//  in       sink       in_data  {cmd, symbol}         in_valid / in_stall
//  out      source     out_data {distance, overflow}  out_valid / out_stall
//  config   slave      4 x 16-bit cost registers      APB, pready always high
//
// For a target symbol the column RAM is swept one entry per cycle through a
// single shared recurrence unit, and the pipeline behind the registered read
// is then drained; with an empty source there is no sweep. Reset clears the
// control state and loads every cost register with 1; the column RAM needs
// no clearing pass, because entries are only read after they have been
// written by an append. An answer is held in an output register, so later
// transactions keep flowing while it waits, and only a second answer stalls
// while the first one is still unclaimed.
//
module weighted_edit_distance_merge_unit #(
	parameter int MAX_SOURCE_LEN = 64
) (
	input  logic            clk,
	input  logic            arst_n,

	input  logic            in_valid,
	output logic            in_stall,
	input  wedm_pkg::in_t   in_data,

	output logic            out_valid,
	input  logic            out_stall,
	output wedm_pkg::out_t  out_data,

	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [3:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);

	wedm_pkg::costs_t     costs_q;
	wedm_pkg::ctrl_cmd_t  command;
	wedm_pkg::dp_status_t status;
	logic [1:0]           reg_idx;
	logic                 cfg_write;

	// Configuration registers. Each register occupies one 32-bit word, and the
	// word index comes straight from the upper address bits.
	assign pready    = 1'b1;
	assign reg_idx   = paddr[3:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			costs_q.replace_cost <= wedm_pkg::COST_RESET;
			costs_q.insert_cost  <= wedm_pkg::COST_RESET;
			costs_q.delete_cost  <= wedm_pkg::COST_RESET;
			costs_q.merge_cost   <= wedm_pkg::COST_RESET;
		end else if (cfg_write) begin
			case (reg_idx)
				wedm_pkg::REG_REPLACE: costs_q.replace_cost <= pwdata[15:0];
				wedm_pkg::REG_INSERT:  costs_q.insert_cost  <= pwdata[15:0];
				wedm_pkg::REG_DELETE:  costs_q.delete_cost  <= pwdata[15:0];
				wedm_pkg::REG_MERGE:   costs_q.merge_cost   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			wedm_pkg::REG_REPLACE: prdata = {16'h0000, costs_q.replace_cost};
			wedm_pkg::REG_INSERT:  prdata = {16'h0000, costs_q.insert_cost};
			wedm_pkg::REG_DELETE:  prdata = {16'h0000, costs_q.delete_cost};
			wedm_pkg::REG_MERGE:   prdata = {16'h0000, costs_q.merge_cost};
			default:               prdata = '0;
		endcase
	end

	// The controller decides which transaction is taken and sequences the
	// column sweep; the datapath owns all problem state and the result register.
	wedm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_cmd   (in_data.cmd),
		.in_stall (in_stall),
		.out_stall(out_stall),
		.status   (status),
		.command  (command)
	);

	wedm_dp #(
		.MAX_SOURCE_LEN(MAX_SOURCE_LEN)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.command  (command),
		.symbol   (in_data.symbol),
		.costs    (costs_q),
		.status   (status),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule
